// ===== hw/rtl/apt_pkg.sv =====
// Shared types and constants for the APT line sync pixel placer.
// No dependencies; imported by apt_div and apt_line_sync_pixel_placer.
package apt_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned HistLen    = 40;
  localparam int unsigned HistDepth  = HistLen - 1;
  localparam int unsigned MatchMin   = 35;
  localparam int unsigned MinWidth   = 80;
  localparam int unsigned MaxWidth   = 4096;

  // Sync patterns, bit i is pattern element i (oldest sample first)
  localparam logic [HistLen-1:0] PatA =
    40'b00000000_0011001100110011001100110011_0000;
  localparam logic [HistLen-1:0] PatB =
    40'b000111_00111_00111_00111_00111_00111_00111_0000;

  // Register indexes
  localparam logic [1:0] RegLineWidth   = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;
  localparam logic [1:0] RegSyncEnable  = 2'd2;

  // Sync kinds
  localparam logic [1:0] SyncNone = 2'd0;
  localparam logic [1:0] SyncA    = 2'd1;
  localparam logic [1:0] SyncB    = 2'd2;

  // Request to the serial divider
  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [15:0] den;
  } apt_div_req_t;

endpackage

// ===== hw/rtl/apt_div.sv =====
// Serial divider for the gray scaling: q = num / den, saturated to 255.
// Depends on apt_pkg (apt_div_req_t).
module apt_div import apt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  apt_div_req_t req_i,
  output logic         done_o,
  output logic [7:0]   q_o
);

  logic [23:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [7:0]  q_q, q_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [23:0] trial;

  // Shifted divisor for the current quotient bit
  assign trial = {8'd0, den_q} << cnt_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      den_d = req_i.den;
      rem_d = req_i.num;
      q_d   = 8'd0;
      cnt_d = 3'd7;
      // quotient of 256 or more saturates at once
      if (req_i.num >= {req_i.den, 8'd0}) begin
        q_d    = 8'hFF;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d        = rem_q - trial;
        q_d[cnt_q]   = 1'b1;
      end
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// ===== hw/rtl/apt_line_sync_pixel_placer.sv =====
// APT line sync detection and pixel placement, top level.
// Depends on apt_pkg and apt_div.
//
// One sample request in, one or more pixel requests out. The sample history
// lives in a 39-entry ring memory with one registered read port; the sync
// correlation walks it one entry per cycle, and every pixel above the level
// floor (with the peak above the floor) is scaled by a shared serial divider.
// A sync match can backfill up to 39 pixels from history ahead of the
// current pixel. The input is taken only while no sample is in work; the
// last pixel waits in an output register so the next sample can already
// enter.
module apt_line_sync_pixel_placer import apt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_level
  // pixel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [11:0] pixel_col, [24:12] pixel_row,
                                      // [32:25] pixel_gray, rest zero
  output logic        m_axis_tlast,   // run_last
  output logic [2:0]  m_axis_tuser,   // [1:0] sync_kind, [2] frame_done
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StCorr   = 10'b0000000010,
    StDecide = 10'b0000000100,
    StBfRd   = 10'b0000001000,
    StBfDiv  = 10'b0000010000,
    StBfWait = 10'b0000100000,
    StBfOut  = 10'b0001000000,
    StSetCol = 10'b0010000000,
    StCurDiv = 10'b0100000000,
    StCurOut = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [12:0] width_cfg_q, height_cfg_q;
  logic        sync_en_q;

  // block state
  logic [15:0] peak_q, peak_d, floor_q, floor_d;
  logic [17:0] smooth_q, smooth_d;
  logic        synced_q, synced_d, finished_q, finished_d;
  logic [11:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [5:0]  wp_q, wp_d;

  // per-sample work registers
  logic [15:0] s_q, s_d;
  logic [5:0]  ci_q, ci_d, ca_q, ca_d, cb_q, cb_d;
  logic [1:0]  kind_q, kind_d;
  logic [11:0] nx_q, nx_d, bf_col_q, bf_col_d;
  logic [5:0]  bf_idx_q, bf_idx_d, bf_left_q, bf_left_d;
  logic [7:0]  gray_q, gray_d;
  logic        gray_wait_q, gray_wait_d;

  // output register
  logic        out_vld_q, out_vld_d;
  logic [11:0] out_col_q, out_col_d;
  logic [12:0] out_row_q, out_row_d;
  logic [7:0]  out_gray_q, out_gray_d;
  logic        out_last_q, out_last_d, out_done_q, out_done_d;
  logic [1:0]  out_kind_q, out_kind_d;

  // history ring memory
  logic [15:0] hist_mem [HistDepth];
  logic [HistDepth-1:0] hist_vld_q;
  logic [15:0] rd_q;
  logic        rd_vld_q;
  logic [5:0]  rd_log, rd_addr;
  logic [6:0]  rd_sum;
  logic        hist_we;
  logic [15:0] hist_val;

  // divider
  apt_div_req_t div_req;
  logic         div_done;
  logic [7:0]   div_q;

  logic        in_acc, out_free, out_load;
  logic [12:0] eff_w;
  logic [17:0] v4;
  logic [15:0] cval;
  logic [5:0]  pi;
  logic [12:0] col_inc, bf_span;
  logic [13:0] row_inc;
  logic [5:0]  bf_len;
  logic [15:0] pix_val;
  logic        pix_zero;
  logic [23:0] num_x256;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;

  // effective line width, clamped
  always_comb begin
    eff_w = width_cfg_q;
    if (width_cfg_q < 13'(MinWidth)) eff_w = 13'(MinWidth);
    if (width_cfg_q > 13'(MaxWidth)) eff_w = 13'(MaxWidth);
  end

  // logical history index to ring address (oldest entry sits at wp)
  always_comb begin
    rd_log = (state_q == StCorr && ci_q != 6'(HistLen)) ? ci_q : bf_idx_q;
    rd_sum = {1'b0, wp_q} + {1'b0, rd_log};
    if (rd_sum >= 7'(HistDepth)) rd_addr = 6'(rd_sum - 7'(HistDepth));
    else                         rd_addr = rd_sum[5:0];
  end

  assign hist_val = rd_vld_q ? rd_q : 16'd0;

  // correlation element
  assign pi   = ci_q - 6'd1;
  assign cval = (ci_q == 6'(HistLen)) ? s_q : hist_val;
  assign v4   = {cval, 2'b00};

  // pixel to scale: backfill entry or current sample
  assign pix_val  = (state_q == StBfDiv) ? hist_val : s_q;
  assign pix_zero = (peak_q <= floor_q) || (pix_val <= floor_q);
  assign num_x256 = {pix_val - floor_q, 8'd0};

  assign col_inc = {1'b0, col_q} + 13'd1;
  assign row_inc = {1'b0, row_q} + 14'd1;
  assign bf_span = {1'b0, nx_d} - {1'b0, col_q};
  assign bf_len  = (bf_span > 13'(HistDepth)) ? 6'(HistDepth) : bf_span[5:0];

  always_comb begin
    state_d     = state_q;
    peak_d      = peak_q;
    floor_d     = floor_q;
    smooth_d    = smooth_q;
    synced_d    = synced_q;
    finished_d  = finished_q;
    col_d       = col_q;
    row_d       = row_q;
    wp_d        = wp_q;
    s_d         = s_q;
    ci_d        = ci_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    kind_d      = kind_q;
    nx_d        = nx_q;
    bf_col_d    = bf_col_q;
    bf_idx_d    = bf_idx_q;
    bf_left_d   = bf_left_q;
    gray_d      = gray_q;
    gray_wait_d = gray_wait_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_gray_d  = out_gray_q;
    out_last_d  = out_last_q;
    out_kind_d  = out_kind_q;
    out_done_d  = out_done_q;
    out_load    = 1'b0;
    hist_we     = 1'b0;
    div_req     = '0;
    div_req.num = num_x256 - {8'd0, pix_val - floor_q};
    div_req.den = peak_q - floor_q;

    case (state_q)
      StIdle: begin
        if (in_acc && !finished_q) begin
          s_d = s_axis_tdata;
          if (s_axis_tdata > peak_q)  peak_d  = s_axis_tdata;
          if (s_axis_tdata < floor_q) floor_d = s_axis_tdata;
          smooth_d = 18'({2'b00, s_axis_tdata} + 20'(({2'b00, smooth_q} * 20'd3) >> 2));
          ci_d     = 6'd0;
          ca_d     = 6'd0;
          cb_d     = 6'd0;
          kind_d   = SyncNone;
          state_d  = sync_en_q ? StCorr : StDecide;
        end
      end
      StCorr: begin
        // read issued for ci, data of ci-1 evaluated
        if (ci_q != 6'd0) begin
          if ((v4 > smooth_q && PatA[pi]) || (v4 < smooth_q && !PatA[pi])) ca_d = ca_q + 6'd1;
          if ((v4 > smooth_q && PatB[pi]) || (v4 < smooth_q && !PatB[pi])) cb_d = cb_q + 6'd1;
        end
        ci_d = ci_q + 6'd1;
        if (ci_q == 6'(HistLen)) state_d = StDecide;
      end
      StDecide: begin
        if (ca_q > 6'(MatchMin))      kind_d = SyncA;
        else if (cb_q > 6'(MatchMin)) kind_d = SyncB;
        nx_d = (kind_d == SyncA) ? 12'(HistDepth) : 12'((eff_w >> 1) + 13'(HistDepth));
        state_d = StSetCol;
        if (kind_d != SyncNone && nx_d > col_q) begin
          bf_left_d = bf_len;
          bf_idx_d  = 6'(HistDepth) - bf_len;
          bf_col_d  = nx_d - 12'(bf_len);
          state_d   = StBfRd;
        end
      end
      StBfRd: begin
        state_d = StBfDiv;
      end
      StBfDiv: begin
        gray_d = 8'd0;
        if (pix_zero) begin
          state_d = StBfOut;
        end else begin
          div_req.start = 1'b1;
          state_d       = StBfWait;
        end
      end
      StBfWait: begin
        if (div_done) begin
          gray_d  = div_q;
          state_d = StBfOut;
        end
      end
      StBfOut: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_col_d  = bf_col_q;
          out_row_d  = row_q;
          out_gray_d = gray_q;
          out_last_d = 1'b0;
          out_kind_d = kind_q;
          out_done_d = 1'b0;
          bf_col_d   = bf_col_q + 12'd1;
          bf_idx_d   = bf_idx_q + 6'd1;
          bf_left_d  = bf_left_q - 6'd1;
          state_d    = (bf_left_q == 6'd1) ? StSetCol : StBfRd;
        end
      end
      StSetCol: begin
        // realign and, on the first sync, restart the levels
        if (kind_q != SyncNone) begin
          col_d = nx_q;
          if (!synced_q) begin
            peak_d   = 16'd0;
            floor_d  = 16'hFFFF;
            synced_d = 1'b1;
          end
        end
        gray_wait_d = 1'b0;
        state_d     = StCurDiv;
      end
      StCurDiv: begin
        if (!gray_wait_q) begin
          gray_d = 8'd0;
          if (pix_zero) begin
            state_d = StCurOut;
          end else begin
            div_req.start = 1'b1;
            gray_wait_d   = 1'b1;
          end
        end else if (div_done) begin
          gray_d  = div_q;
          state_d = StCurOut;
        end
      end
      StCurOut: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_col_d  = col_q;
          out_row_d  = row_q;
          out_gray_d = gray_q;
          out_last_d = 1'b1;
          out_kind_d = kind_q;
          out_done_d = 1'b0;
          // advance with line and image wrap
          col_d = col_inc[11:0];
          if (col_inc >= eff_w) begin
            col_d = 12'd0;
            row_d = row_inc[12:0];
            if (row_inc >= {1'b0, height_cfg_q}) begin
              row_d      = 13'd0;
              finished_d = 1'b1;
              out_done_d = 1'b1;
            end
          end
          hist_we = 1'b1;
          wp_d    = (wp_q == 6'(HistDepth - 1)) ? 6'd0 : wp_q + 6'd1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    out_vld_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
  end

  apt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .q_o    (div_q)
  );

  // history memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[wp_q] <= s_q;
    rd_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (hist_we) hist_vld_q[wp_q] <= 1'b1;
      rd_vld_q <= hist_vld_q[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= 13'd2080;
      height_cfg_q <= 13'd1800;
      sync_en_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLineWidth:   width_cfg_q  <= cfg_data_i;
        RegImageHeight: height_cfg_q <= cfg_data_i;
        RegSyncEnable:  sync_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      peak_q      <= 16'd0;
      floor_q     <= 16'hFFFF;
      smooth_q    <= 18'd0;
      synced_q    <= 1'b0;
      finished_q  <= 1'b0;
      col_q       <= 12'd0;
      row_q       <= 13'd0;
      wp_q        <= 6'd0;
      out_vld_q   <= 1'b0;
      gray_wait_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      floor_q     <= floor_d;
      smooth_q    <= smooth_d;
      synced_q    <= synced_d;
      finished_q  <= finished_d;
      col_q       <= col_d;
      row_q       <= row_d;
      wp_q        <= wp_d;
      out_vld_q   <= out_vld_d;
      gray_wait_q <= gray_wait_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    ci_q       <= ci_d;
    ca_q       <= ca_d;
    cb_q       <= cb_d;
    kind_q     <= kind_d;
    nx_q       <= nx_d;
    bf_col_q   <= bf_col_d;
    bf_idx_q   <= bf_idx_d;
    bf_left_q  <= bf_left_d;
    gray_q     <= gray_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_gray_q <= out_gray_d;
    out_last_q <= out_last_d;
    out_kind_q <= out_kind_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_gray_q, out_row_q, out_col_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_done_q, out_kind_q};

endmodule
